/* sv/sdf_pkg.sv */
// Shared types and constants for the SD SPI command framer.
package sdf_pkg;

   // Input kinds carried on req_tuser
   localparam logic ACT_COMMAND  = 1'b0;
   localparam logic ACT_RESPONSE = 1'b1;

   // Result kinds carried on rsp_tuser
   localparam logic KIND_TRANSMIT = 1'b0;
   localparam logic KIND_OUTCOME  = 1'b1;

   // Outcome codes
   localparam logic [2:0] OC_FOUND    = 3'd0;
   localparam logic [2:0] OC_TIMEOUT  = 3'd1;
   localparam logic [2:0] OC_ALL_ZERO = 3'd2;
   localparam logic [2:0] OC_ALL_ONES = 3'd3;
   localparam logic [2:0] OC_MIXED    = 3'd4;

   // Frame constants
   localparam logic [7:0] LEAD_BYTE  = 8'hFF;
   localparam logic [7:0] START_BITS = 8'h40;
   localparam logic [6:0] CRC_POLY   = 7'h09;
   localparam logic [7:0] NO_R1      = 8'hFF;
   localparam logic [5:0] NO_POS     = 6'h3F;

   // Frame byte index of the CRC byte (last of seven)
   localparam logic [2:0] CRC_SLOT   = 3'd6;

   // One result item
   typedef struct packed {
      logic       kind;
      logic [7:0] transmit_byte;
      logic       last_of_frame;
      logic [7:0] r1_value;
      logic [5:0] r1_position;
      logic [2:0] outcome;
   } rsp_item_type;

endpackage

/* sv/sdf_framer.sv */
// Frame byte sequencer with a running CRC7, one frame byte per step.
module sdf_framer
   import sdf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  logic         out_free,
   input  logic [5:0]   command_index,
   input  logic [31:0]  argument,
   input  logic [7:0]   crc_override,
   output logic         emit,
   output logic         done,
   output rsp_item_type item
);

   logic [2:0] idx_ff, idx_in;
   logic [6:0] acc_ff, acc_in;
   logic [7:0] frame_byte;

   // One byte of CRC7, bit by bit (eight dependent steps)
   function automatic logic [6:0] crc7_feed(input logic [6:0] acc, input logic [7:0] b);
      logic [6:0] a;
      logic [7:0] d;
      logic       fb;
      a = acc;
      d = b;
      for (int k = 0; k < 8; k++) begin
         fb = d[7] ^ a[6];
         a  = {a[5:0], 1'b0} ^ (fb ? CRC_POLY : 7'h00);
         d  = {d[6:0], 1'b0};
      end
      return a;
   endfunction

   // Select the frame byte for the current slot
   always_comb begin
      case (idx_ff)
         3'd0:    frame_byte = LEAD_BYTE;
         3'd1:    frame_byte = START_BITS | {2'b00, command_index};
         3'd2:    frame_byte = argument[31:24];
         3'd3:    frame_byte = argument[23:16];
         3'd4:    frame_byte = argument[15:8];
         3'd5:    frame_byte = argument[7:0];
         default: frame_byte = (crc_override != 8'h00) ? crc_override : {acc_ff, 1'b1};
      endcase
   end

   assign emit = cmd_valid && out_free;
   assign done = emit && (idx_ff == CRC_SLOT);

   // Slot counter and CRC accumulator
   always_comb begin
      idx_in = idx_ff;
      acc_in = acc_ff;
      if (emit) begin
         if (idx_ff == CRC_SLOT) begin
            idx_in = 3'd0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
         if (idx_ff == 3'd0) begin
            acc_in = 7'h00;
         end else if (idx_ff != CRC_SLOT) begin
            acc_in = crc7_feed(acc_ff, frame_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else begin
         idx_ff <= idx_in;
      end
      acc_ff <= acc_in;
   end

   // Transmit result item
   always_comb begin
      item               = '0;
      item.kind          = KIND_TRANSMIT;
      item.transmit_byte = frame_byte;
      item.last_of_frame = (idx_ff == CRC_SLOT);
   end

endmodule

/* sv/sdf_hunter.sv */
// R1 response hunter: normal poll with timeout, or trace scan with classification.
module sdf_hunter
   import sdf_pkg::*;
#(
   parameter int POLL_LIMIT = 16,
   parameter int TRACE_LEN  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_start,
   input  logic         trace_mode,
   input  logic         byte_valid,
   input  logic [7:0]   response_byte,
   output logic         hunting,
   output logic         res_valid,
   output rsp_item_type res
);

   localparam logic [6:0] PollLim  = 7'(POLL_LIMIT);
   localparam logic [6:0] TraceLim = 7'(TRACE_LEN);

   logic       hunting_ff, hunting_in;
   logic       tracing_ff, tracing_in;
   logic [5:0] count_ff, count_in;
   logic [7:0] fval_ff, fval_in;
   logic [5:0] fpos_ff, fpos_in;
   logic       zero_ff, zero_in;
   logic       ones_ff, ones_in;

   logic [6:0] next_cnt;
   logic       clear;
   logic       z, o;
   logic [7:0] fv;
   logic [5:0] fp;

   assign next_cnt = {1'b0, count_ff} + 7'd1;
   assign hunting  = hunting_ff;

   // Hunt step
   always_comb begin
      hunting_in = hunting_ff;
      tracing_in = tracing_ff;
      count_in   = count_ff;
      fval_in    = fval_ff;
      fpos_in    = fpos_ff;
      zero_in    = zero_ff;
      ones_in    = ones_ff;
      clear      = 1'b0;
      res_valid  = 1'b0;
      res        = '0;
      res.kind   = KIND_OUTCOME;
      res.r1_value    = NO_R1;
      res.r1_position = NO_POS;
      z  = zero_ff && (response_byte == 8'h00);
      o  = ones_ff && (response_byte == 8'hFF);
      fv = fval_ff;
      fp = fpos_ff;
      if (fpos_ff == NO_POS && count_ff != 6'h3F && !response_byte[7]) begin
         fv = response_byte;
         fp = count_ff;
      end

      if (cmd_start) begin
         clear = 1'b1;
      end else if (byte_valid && hunting_ff) begin
         if (!tracing_ff) begin
            // Normal mode: first byte with bit 7 clear is R1
            if (!response_byte[7]) begin
               res_valid       = 1'b1;
               res.r1_value    = response_byte;
               res.r1_position = count_ff;
               res.outcome     = OC_FOUND;
               clear           = 1'b1;
            end else if (next_cnt >= PollLim) begin
               res_valid   = 1'b1;
               res.outcome = OC_TIMEOUT;
               clear       = 1'b1;
            end else begin
               count_in = next_cnt[5:0];
            end
         end else begin
            // Trace mode: scan the window, then classify
            if (next_cnt >= TraceLim) begin
               res_valid = 1'b1;
               clear     = 1'b1;
               if (z) begin
                  res.outcome = OC_ALL_ZERO;
               end else if (o) begin
                  res.outcome = OC_ALL_ONES;
               end else if (fp != NO_POS) begin
                  res.r1_value    = fv;
                  res.r1_position = fp;
                  res.outcome     = OC_FOUND;
               end else begin
                  res.outcome = OC_MIXED;
               end
            end else begin
               count_in = next_cnt[5:0];
               zero_in  = z;
               ones_in  = o;
               fval_in  = fv;
               fpos_in  = fp;
            end
         end
      end

      if (clear) begin
         hunting_in = cmd_start;
         tracing_in = cmd_start && trace_mode;
         count_in   = 6'd0;
         fval_in    = NO_R1;
         fpos_in    = NO_POS;
         zero_in    = 1'b1;
         ones_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunting_ff <= 1'b0;
         tracing_ff <= 1'b0;
         count_ff   <= 6'd0;
         fval_ff    <= NO_R1;
         fpos_ff    <= NO_POS;
         zero_ff    <= 1'b1;
         ones_ff    <= 1'b1;
      end else begin
         hunting_ff <= hunting_in;
         tracing_ff <= tracing_in;
         count_ff   <= count_in;
         fval_ff    <= fval_in;
         fpos_ff    <= fpos_in;
         zero_ff    <= zero_in;
         ones_ff    <= ones_in;
      end
   end

endmodule

/* sv/sd_spi_command_framer_unit.sv */
// Top level of the SD SPI command framer and R1 hunter.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+--------------------------------------
//  req_     | in  | req_tvalid/tready    | tdata command fields + byte, tuser action
//  rsp_     | out | rsp_tvalid/tready    | tdata byte/R1/position/outcome, tuser kind,
//           |     |                      | tlast on CRC byte
//
// A command item emits its seven frame bytes in order, stepped by the frame slot
// counter whenever the output register is free; a response byte item feeds the hunter.
// Items enter an input register and results leave through an output register,
// so a new item can enter an empty input register while a finished result waits.
// Synchronous active-high reset clears the hunt state and both valid flags.
// A stalled rsp_tready holds the output register and then the input register.
module sd_spi_command_framer_unit
   import sdf_pkg::*;
#(
   parameter int POLL_LIMIT = 16,
   parameter int TRACE_LEN  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [5:0] command_index, [37:6] argument, [45:38] crc_override,
   // [46] trace_mode, [54:47] response_byte, [55] zero
   input  logic [55:0] req_tdata,
   // [0] action
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] transmit_byte, [15:8] r1_value, [21:16] r1_position,
   // [24:22] outcome, [31:25] zero
   output logic [31:0] rsp_tdata,
   // [0] result_kind
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   logic         in_valid_ff, in_valid_in;
   logic [55:0]  in_data_ff;
   logic         in_action_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic         out_free;
   logic         in_release;
   logic         frm_emit, frm_done;
   rsp_item_type frm_item;
   logic         hunt_byte;
   logic         hunting;
   logic         hunt_valid;
   rsp_item_type hunt_item;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign hunt_byte  = in_valid_ff && (in_action_ff == ACT_RESPONSE) && out_free;
   assign in_release = frm_done || hunt_byte;
   assign req_tready = !in_valid_ff || in_release;

   // Frame sequencer
   sdf_framer u_framer (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (in_valid_ff && (in_action_ff == ACT_COMMAND)),
      .out_free      (out_free),
      .command_index (in_data_ff[5:0]),
      .argument      (in_data_ff[37:6]),
      .crc_override  (in_data_ff[45:38]),
      .emit          (frm_emit),
      .done          (frm_done),
      .item          (frm_item)
   );

   // Response hunter
   sdf_hunter #(
      .POLL_LIMIT (POLL_LIMIT),
      .TRACE_LEN  (TRACE_LEN)
   ) u_hunter (
      .clock         (clock),
      .reset         (reset),
      .cmd_start     (frm_done),
      .trace_mode    (in_data_ff[46]),
      .byte_valid    (hunt_byte),
      .response_byte (in_data_ff[54:47]),
      .hunting       (hunting),
      .res_valid     (hunt_valid),
      .res           (hunt_item)
   );

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (out_free) begin
         out_valid_in = frm_emit || hunt_valid;
         out_item_in  = frm_emit ? frm_item : hunt_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_tready && req_tvalid) begin
         in_data_ff   <= req_tdata;
         in_action_ff <= req_tuser;
      end
      out_item_ff <= out_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.kind;
   assign rsp_tlast  = out_item_ff.last_of_frame;
   assign rsp_tdata  = {7'b0, out_item_ff.outcome, out_item_ff.r1_position,
                        out_item_ff.r1_value, out_item_ff.transmit_byte};

`ifndef SYNTH
   // The CRC byte is always a transmit item
   a_last_is_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_TRANSMIT)
      else $error("tlast on a non-transmit item");

   // Finishing a frame arms the hunt
   a_frame_arms: assert property (@(posedge clock) disable iff (reset)
      frm_done |=> hunting)
      else $error("hunt not armed after frame");

   // A reported R1 always has bit 7 clear
   a_r1_bit7: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_OUTCOME && rsp_tdata[24:22] == OC_FOUND
      |-> !rsp_tdata[15])
      else $error("R1 reported with bit 7 set");

   // Outcome codes stay in range
   a_outcome_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_OUTCOME |-> rsp_tdata[24:22] <= OC_MIXED)
      else $error("outcome code out of range");
`endif

endmodule
